// ----- hw/rtl/tmap_pkg.sv -----
// ----------------------------------------------------------------------------
// tmap_pkg - shared types and constants for the touch event to point mapper
// Event codes, register map, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package tmap_pkg;

  // Event types
  localparam logic [15:0] EVT_SYN = 16'h0000;
  localparam logic [15:0] EVT_KEY = 16'h0001;
  localparam logic [15:0] EVT_ABS = 16'h0003;

  // Event codes
  localparam logic [15:0] CODE_TOUCH_BUTTON = 16'h014a;
  localparam logic [15:0] CODE_POS_X        = 16'h0035;
  localparam logic [15:0] CODE_POS_Y        = 16'h0036;
  localparam logic [15:0] CODE_TRACK_ID     = 16'h0039;
  localparam logic [31:0] TRACK_RELEASE     = 32'hffff_ffff;

  // Register map (word index = paddr[4:2])
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_LOGICAL_WIDTH  = 3'd0;
  localparam logic [2:0] REG_LOGICAL_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROTATE_MODE    = 3'd2;
  localparam logic [2:0] REG_RAW_X_MAX      = 3'd3;
  localparam logic [2:0] REG_RAW_Y_MAX      = 3'd4;

  // Register reset values
  localparam logic [12:0] LOGICAL_WIDTH_RST  = 13'd1280;
  localparam logic [12:0] LOGICAL_HEIGHT_RST = 13'd800;
  localparam logic        ROTATE_MODE_RST    = 1'b1;
  localparam logic [15:0] RAW_X_MAX_RST      = 16'd1280;
  localparam logic [15:0] RAW_Y_MAX_RST      = 16'd800;

  localparam logic [12:0] SCREEN_MAX = 13'd4096;

  // Quotient bits resolved by the divider; larger quotients saturate
  localparam int unsigned QUO_W = 13;
  localparam int unsigned MAG_W = 45;   // |pos| (32b) * size (13b)
  localparam int unsigned REM_W = 16 + QUO_W;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } event_t;

  typedef struct packed {
    logic [11:0] point_x;
    logic [11:0] point_y;
    logic        is_pressed;
  } point_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } state_e;

  // Screen size saturated to 1..4096
  function automatic logic [12:0] screen_size(input logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > SCREEN_MAX) begin
      r = SCREEN_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Raw maximum, zero taken as one
  function automatic logic [15:0] raw_max(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

// ----- hw/rtl/touch_event_to_point_mapper.sv -----
// ----------------------------------------------------------------------------
// touch_event_to_point_mapper - touch controller events to screen points
// Tracks button/position state and scales the raw position on each sync.
// ----------------------------------------------------------------------------
// Events are taken one per transfer. Key and absolute events update the
// touch state in the cycle they are accepted; these and ignored events yield
// no result, so the block is ready again on the next cycle. A sync event
// yields one point and keeps the input stalled until it is done: per axis
// ST_MUL multiplies the magnitude of the raw position by the saturated screen
// size, ST_CHK compares against the divisor shifted by 13 (larger quotients
// saturate and skip the divider, which the clamp makes harmless), ST_DIV runs
// a shared restoring divider one quotient bit at a time, and ST_FIN applies
// sign, flip and clamp. Division truncates toward zero. The point lands in an
// output register, so the block accepts further events while a point waits
// to be taken; a second sync finishing before that only holds in its last
// step. Configuration is a small APB register file (byte addresses
// 0x00..0x10), to be written only when idle; the block does not enforce it.
module touch_event_to_point_mapper (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // event input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tmap_pkg::event_t                in_data_i,
  // point output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tmap_pkg::point_t                out_data_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tmap_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [12:0] lw_q, lh_q;
  logic        rot_q;
  logic [15:0] xm_q, ym_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q  <= tmap_pkg::LOGICAL_WIDTH_RST;
      lh_q  <= tmap_pkg::LOGICAL_HEIGHT_RST;
      rot_q <= tmap_pkg::ROTATE_MODE_RST;
      xm_q  <= tmap_pkg::RAW_X_MAX_RST;
      ym_q  <= tmap_pkg::RAW_Y_MAX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tmap_pkg::REG_LOGICAL_WIDTH:  lw_q  <= pwdata[12:0];
        tmap_pkg::REG_LOGICAL_HEIGHT: lh_q  <= pwdata[12:0];
        tmap_pkg::REG_ROTATE_MODE:    rot_q <= pwdata[0];
        tmap_pkg::REG_RAW_X_MAX:      xm_q  <= pwdata[15:0];
        tmap_pkg::REG_RAW_Y_MAX:      ym_q  <= pwdata[15:0];
        default: ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tmap_pkg::REG_LOGICAL_WIDTH:  prdata = {19'd0, lw_q};
      tmap_pkg::REG_LOGICAL_HEIGHT: prdata = {19'd0, lh_q};
      tmap_pkg::REG_ROTATE_MODE:    prdata = {31'd0, rot_q};
      tmap_pkg::REG_RAW_X_MAX:      prdata = {16'd0, xm_q};
      tmap_pkg::REG_RAW_Y_MAX:      prdata = {16'd0, ym_q};
      default:                      prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Touch state and sequencer registers
  // --------------------------------------------------------------------------
  tmap_pkg::state_e state_q, state_d;

  logic signed [31:0] raw_x_q, raw_x_d, raw_y_q, raw_y_d;
  logic               pressed_q, pressed_d, has_btn_q, has_btn_d;

  logic                          axis_q, axis_d;       // 0: point_x, 1: point_y
  logic [tmap_pkg::MAG_W-1:0]    mag_q, mag_d;         // |pos| * size
  logic                          neg_q, neg_d;         // product sign
  logic [15:0]                   div_q, div_d;         // divisor
  logic [12:0]                   size_q, size_d;       // saturated screen size
  logic [tmap_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [tmap_pkg::REM_W-1:0]    dsh_q, dsh_d;         // shifted divisor
  logic [tmap_pkg::QUO_W-1:0]    quo_q, quo_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic [11:0]                   res_x_q, res_x_d;

  logic             out_valid_q, out_valid_d;
  tmap_pkg::point_t out_data_q, out_data_d;

  logic in_acc;
  assign in_stall_o  = (state_q != tmap_pkg::ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Datapath helpers
  logic               sel_y;        // operand from raw Y
  logic signed [31:0] raw_sel;
  logic [31:0]        raw_abs;
  logic [12:0]        size_sel;
  logic               ge;
  logic [12:0]        size_m1;
  logic [11:0]        axis_val;
  logic               flip;

  always_comb begin
    sel_y    = rot_q ^ axis_q;
    raw_sel  = sel_y ? raw_y_q : raw_x_q;
    raw_abs  = raw_sel[31] ? (~raw_sel + 32'd1) : raw_sel;
    size_sel = axis_q ? tmap_pkg::screen_size(lh_q) : tmap_pkg::screen_size(lw_q);
    ge       = (rem_q >= dsh_q);
    size_m1  = size_q - 13'd1;
    flip     = rot_q & ~axis_q;

    // Sign, rotation flip and clamp of the saturated quotient
    if (flip) begin
      // x = size - q
      if (neg_q) begin
        axis_val = size_m1[11:0];
      end else if ({3'd0, quo_q} >= {3'd0, size_q}) begin
        axis_val = 12'd0;
      end else if (quo_q == '0) begin
        axis_val = size_m1[11:0];
      end else begin
        axis_val = 12'(size_q - quo_q);
      end
    end else begin
      if (neg_q) begin
        axis_val = 12'd0;
      end else if (quo_q > size_m1) begin
        axis_val = size_m1[11:0];
      end else begin
        axis_val = quo_q[11:0];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    raw_x_d     = raw_x_q;
    raw_y_d     = raw_y_q;
    pressed_d   = pressed_q;
    has_btn_d   = has_btn_q;
    axis_d      = axis_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    div_d       = div_q;
    size_d      = size_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    res_x_d     = res_x_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      tmap_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (in_data_i.event_type == tmap_pkg::EVT_KEY) begin
            if (in_data_i.event_code == tmap_pkg::CODE_TOUCH_BUTTON) begin
              has_btn_d = 1'b1;
              pressed_d = (in_data_i.event_value != 32'sd0);
            end
          end else if (in_data_i.event_type == tmap_pkg::EVT_ABS) begin
            priority if (in_data_i.event_code == tmap_pkg::CODE_POS_X) begin
              raw_x_d = in_data_i.event_value;
            end else if (in_data_i.event_code == tmap_pkg::CODE_POS_Y) begin
              raw_y_d = in_data_i.event_value;
            end else if (in_data_i.event_code == tmap_pkg::CODE_TRACK_ID) begin
              if (in_data_i.event_value == tmap_pkg::TRACK_RELEASE) begin
                pressed_d = 1'b0;
              end else if (!has_btn_q) begin
                pressed_d = 1'b1;
              end
            end else begin
              // other absolute codes ignored
            end
          end else if (in_data_i.event_type == tmap_pkg::EVT_SYN) begin
            axis_d  = 1'b0;
            state_d = tmap_pkg::ST_MUL;
          end else begin
            // other event types ignored
          end
        end
      end

      tmap_pkg::ST_MUL: begin
        mag_d   = tmap_pkg::MAG_W'(raw_abs) * tmap_pkg::MAG_W'(size_sel);
        neg_d   = raw_sel[31];
        div_d   = sel_y ? tmap_pkg::raw_max(ym_q) : tmap_pkg::raw_max(xm_q);
        size_d  = size_sel;
        state_d = tmap_pkg::ST_CHK;
      end

      tmap_pkg::ST_CHK: begin
        if (mag_q >= tmap_pkg::MAG_W'({div_q, 13'd0})) begin
          quo_d   = '1;   // saturated, beyond any screen
          state_d = tmap_pkg::ST_FIN;
        end else begin
          rem_d   = mag_q[tmap_pkg::REM_W-1:0];
          dsh_d   = {1'b0, div_q, 12'd0};
          quo_d   = '0;
          cnt_d   = 4'(tmap_pkg::QUO_W - 1);
          state_d = tmap_pkg::ST_DIV;
        end
      end

      tmap_pkg::ST_DIV: begin
        rem_d = ge ? (rem_q - dsh_q) : rem_q;
        quo_d = {quo_q[tmap_pkg::QUO_W-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          state_d = tmap_pkg::ST_FIN;
        end
      end

      tmap_pkg::ST_FIN: begin
        if (!axis_q) begin
          res_x_d = axis_val;
          axis_d  = 1'b1;
          state_d = tmap_pkg::ST_MUL;
        end else if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_data_d.point_x    = res_x_q;
          out_data_d.point_y    = axis_val;
          out_data_d.is_pressed = pressed_q;
          state_d               = tmap_pkg::ST_IDLE;
        end
      end

      default: state_d = tmap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmap_pkg::ST_IDLE;
      raw_x_q     <= '0;
      raw_y_q     <= '0;
      pressed_q   <= 1'b0;
      has_btn_q   <= 1'b0;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      raw_x_q     <= raw_x_d;
      raw_y_q     <= raw_y_d;
      pressed_q   <= pressed_d;
      has_btn_q   <= has_btn_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    div_q      <= div_d;
    size_q     <= size_d;
    rem_q      <= rem_d;
    dsh_q      <= dsh_d;
    quo_q      <= quo_d;
    res_x_q    <= res_x_d;
    out_data_q <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  // Restoring divider keeps the partial remainder below twice the shifted divisor
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tmap_pkg::ST_DIV |-> {1'b0, rem_q} < {dsh_q, 1'b0})
    else $error("divider remainder out of range");

  // A new point appears only from the last step of the Y axis
  a_point_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tmap_pkg::ST_FIN && axis_q))
    else $error("point produced outside final step");

  // Non-sync events leave the sequencer idle
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.event_type != tmap_pkg::EVT_SYN
      |=> state_q == tmap_pkg::ST_IDLE)
    else $error("non-sync event started a computation");

  // Delivered point lies on the screen
  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, out_data_q.point_x} < tmap_pkg::screen_size(lw_q)) &&
                    ({1'b0, out_data_q.point_y} < tmap_pkg::screen_size(lh_q)))
    else $error("point outside screen");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb - self-checking bench for touch_event_to_point_mapper
// Streams touch events through the valid/stall input, predicts every point
// the block should produce, and checks each output transfer in order. The
// screen and rotation registers are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHUNK_ITEMS    = 155;   // counted events per random phase
  localparam int unsigned NUM_CHUNKS     = 9;
  localparam int unsigned HOLD_CYCLES    = 600;   // long output hold-off
  localparam int unsigned DRAIN_CYCLES   = 40;    // > one full sync computation
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int unsigned MAX_REPORTS    = 100;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT hookup
  // --------------------------------------------------------------------------
  logic   clk_i;
  logic   rst_ni   = 1'b0;

  logic             ev_valid = 1'b0;
  logic             ev_stall;
  tmap_pkg::event_t ev_data  = '0;

  logic             pt_valid;
  logic             pt_stall = 1'b0;
  tmap_pkg::point_t pt_data;

  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [tmap_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                 pwdata  = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // Transfer strobes, valid at the rising edge on pre-edge values
  wire ev_fire = ev_valid && !ev_stall;
  wire pt_fire = pt_valid && !pt_stall;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  touch_event_to_point_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ev_valid),
    .in_stall_o  (ev_stall),
    .in_data_i   (ev_data),
    .out_valid_o (pt_valid),
    .out_stall_i (pt_stall),
    .out_data_o  (pt_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  tmap_pkg::event_t pending_events[$];    // filled by the stimulus, drained by the driver
  tmap_pkg::point_t expected_points[$];   // predicted points, oldest first

  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned hold_requests     = 0;  // bumped by the stimulus, served by the monitor

  int unsigned items_queued    = 0;   // meaningful events queued in the current phase
  int unsigned events_accepted = 0;
  int unsigned points_checked  = 0;
  int unsigned settings_used   = 0;
  int unsigned error_count     = 0;

  // Predictor copy of the touch state
  logic signed [31:0] touch_x     = '0;
  logic signed [31:0] touch_y     = '0;
  logic               touch_down  = 1'b0;
  logic               button_seen = 1'b0;

  // Predictor copy of the registers (reset values)
  logic [12:0] scr_width  = tmap_pkg::LOGICAL_WIDTH_RST;
  logic [12:0] scr_height = tmap_pkg::LOGICAL_HEIGHT_RST;
  logic        scr_rotate = tmap_pkg::ROTATE_MODE_RST;
  logic [15:0] raw_x_span = tmap_pkg::RAW_X_MAX_RST;
  logic [15:0] raw_y_span = tmap_pkg::RAW_Y_MAX_RST;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [11:0] fit_to_screen(input longint v, input longint size);
    longint r;
    if (v < 0) begin
      r = 0;
    end else if (v > size - 1) begin
      r = size - 1;
    end else begin
      r = v;
    end
    return r[11:0];
  endfunction

  // Update the touch state for one accepted event; a sync adds one point.
  function automatic void apply_touch_event(input tmap_pkg::event_t ev);
    longint lw, lh, xm, ym, px, py;
    tmap_pkg::point_t pt;
    case (ev.event_type)
      tmap_pkg::EVT_KEY: begin
        if (ev.event_code == tmap_pkg::CODE_TOUCH_BUTTON) begin
          button_seen = 1'b1;
          touch_down  = (ev.event_value != 0);
        end
      end
      tmap_pkg::EVT_ABS: begin
        if (ev.event_code == tmap_pkg::CODE_POS_X) begin
          touch_x = ev.event_value;
        end else if (ev.event_code == tmap_pkg::CODE_POS_Y) begin
          touch_y = ev.event_value;
        end else if (ev.event_code == tmap_pkg::CODE_TRACK_ID) begin
          if ($unsigned(ev.event_value) == tmap_pkg::TRACK_RELEASE) begin
            touch_down = 1'b0;
          end else if (!button_seen) begin
            touch_down = 1'b1;
          end
        end
      end
      tmap_pkg::EVT_SYN: begin
        // saturate sizes to 1..4096, a zero raw span counts as one
        lw = (scr_width == 0) ? 1 :
             ((scr_width > tmap_pkg::SCREEN_MAX) ? longint'(tmap_pkg::SCREEN_MAX)
                                                 : longint'(scr_width));
        lh = (scr_height == 0) ? 1 :
             ((scr_height > tmap_pkg::SCREEN_MAX) ? longint'(tmap_pkg::SCREEN_MAX)
                                                  : longint'(scr_height));
        xm = (raw_x_span == 0) ? 1 : longint'(raw_x_span);
        ym = (raw_y_span == 0) ? 1 : longint'(raw_y_span);
        if (scr_rotate) begin
          px = lw - (longint'(touch_y) * lw) / ym;
          py = (longint'(touch_x) * lh) / xm;
        end else begin
          px = (longint'(touch_x) * lw) / xm;
          py = (longint'(touch_y) * lh) / ym;
        end
        pt.point_x    = fit_to_screen(px, lw);
        pt.point_y    = fit_to_screen(py, lh);
        pt.is_pressed = touch_down;
        expected_points.push_back(pt);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("tb: mismatch: %s", msg);
    end
  endtask

  // --------------------------------------------------------------------------
  // Event driver: offers the next pending event, holds it while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : event_driver
    if (!rst_ni) begin
      ev_valid <= 1'b0;
    end else begin
      if (ev_fire) begin
        apply_touch_event(ev_data);
        events_accepted++;
      end
      // a stalled transfer keeps valid and payload untouched
      if (!ev_valid || !ev_stall) begin
        if (pending_events.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          ev_data  <= pending_events.pop_front();
          ev_valid <= 1'b1;
        end else begin
          ev_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Point monitor: checks each output transfer, drives the output stall
  // --------------------------------------------------------------------------
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  always @(posedge clk_i) begin : point_monitor
    tmap_pkg::point_t want;
    logic             stall_next;
    if (!rst_ni) begin
      pt_stall <= 1'b0;
    end else begin
      if (pt_fire) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point x=%0d y=%0d pressed=%0b",
                                    pt_data.point_x, pt_data.point_y, pt_data.is_pressed));
        end else begin
          want = expected_points.pop_front();
          if (pt_data.point_x !== want.point_x) begin
            report_mismatch($sformatf("point %0d: point_x got %0d want %0d",
                                      points_checked, pt_data.point_x, want.point_x));
          end
          if (pt_data.point_y !== want.point_y) begin
            report_mismatch($sformatf("point %0d: point_y got %0d want %0d",
                                      points_checked, pt_data.point_y, want.point_y));
          end
          if (pt_data.is_pressed !== want.is_pressed) begin
            report_mismatch($sformatf("point %0d: is_pressed got %0b want %0b",
                                      points_checked, pt_data.is_pressed, want.is_pressed));
          end
          points_checked++;
        end
      end
      // long hold-off when requested, otherwise random stalls
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left  = HOLD_CYCLES;
        stall_next = 1'b1;
      end else begin
        stall_next = ($urandom_range(0, 99) < receiver_idle_pct);
      end
      pt_stall <= stall_next;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: ends the run when nothing moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || ev_fire || pt_fire) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: timeout after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // APB write: setup cycle, access cycle, done at the edge where pready is high.
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tmap_pkg::REG_LOGICAL_WIDTH:  scr_width  = value[12:0];
      tmap_pkg::REG_LOGICAL_HEIGHT: scr_height = value[12:0];
      tmap_pkg::REG_ROTATE_MODE:    scr_rotate = value[0];
      tmap_pkg::REG_RAW_X_MAX:      raw_x_span = value[15:0];
      tmap_pkg::REG_RAW_Y_MAX:      raw_y_span = value[15:0];
      default: ;
    endcase
  endtask

  // Queue one event; only events the block acts on count toward the phase size.
  function automatic void queue_event(input logic [15:0] etype, input logic [15:0] ecode,
                                      input logic [31:0] evalue);
    tmap_pkg::event_t ev;
    ev.event_type  = etype;
    ev.event_code  = ecode;
    ev.event_value = evalue;
    pending_events.push_back(ev);
    if (etype == tmap_pkg::EVT_SYN ||
        (etype == tmap_pkg::EVT_KEY && ecode == tmap_pkg::CODE_TOUCH_BUTTON) ||
        (etype == tmap_pkg::EVT_ABS &&
         ecode inside {tmap_pkg::CODE_POS_X, tmap_pkg::CODE_POS_Y,
                       tmap_pkg::CODE_TRACK_ID})) begin
      items_queued++;
    end
  endfunction

  // Raw position around the controller range, with negative and huge outliers
  function automatic logic [31:0] pick_position(input logic [15:0] span);
    int unsigned m, r;
    logic [31:0] v;
    m = (span == 0) ? 1 : span;
    r = $urandom_range(0, 11);
    case (r)
      0:       v = $urandom;
      1:       v = 32'(0 - $urandom_range(1, 2000));
      2:       v = m;
      3:       v = 0;
      4:       v = m + $urandom_range(1, 5000);
      default: v = $urandom_range(0, m);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_track_id();
    if ($urandom_range(0, 3) == 0) begin
      return tmap_pkg::TRACK_RELEASE;
    end
    return ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 9));
  endfunction

  function automatic logic [31:0] pick_button_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      return 32'd0;
    end
    return (r < 9) ? 32'd1 : 32'($urandom);
  endfunction

  function automatic void queue_sync();
    if ($urandom_range(0, 9) == 0) begin
      queue_event(tmap_pkg::EVT_SYN, 16'($urandom), $urandom);   // code and value do not matter
    end else begin
      queue_event(tmap_pkg::EVT_SYN, 16'h0000, 32'h0);
    end
  endfunction

  // One random touch frame: mostly well formed, some broken, some noise.
  function automatic void queue_touch_frame();
    int unsigned kind, n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_event(tmap_pkg::EVT_KEY, tmap_pkg::CODE_TOUCH_BUTTON, pick_button_level());
      end
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 9) != 0)
          queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_X, pick_position(raw_x_span));
        if ($urandom_range(0, 9) != 0)
          queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_Y, pick_position(raw_y_span));
      end else begin
        if ($urandom_range(0, 9) != 0)
          queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_Y, pick_position(raw_y_span));
        if ($urandom_range(0, 9) != 0)
          queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_X, pick_position(raw_x_span));
      end
      if ($urandom_range(0, 1) == 0) begin
        queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_TRACK_ID, pick_track_id());
      end
      queue_sync();
    end else if (kind < 88) begin
      // broken frame: loose state updates, or a bare sync
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0: queue_event(tmap_pkg::EVT_KEY, tmap_pkg::CODE_TOUCH_BUTTON, pick_button_level());
          1: queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_X, pick_position(raw_x_span));
          2: queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_Y, pick_position(raw_y_span));
          3: queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_TRACK_ID, pick_track_id());
          default: queue_sync();
        endcase
      end
    end else begin
      // noise: arbitrary type, or a known type with an arbitrary code
      case ($urandom_range(0, 2))
        0: queue_event(16'($urandom), 16'($urandom), $urandom);
        1: queue_event(tmap_pkg::EVT_KEY, 16'($urandom), $urandom);
        default: queue_event(tmap_pkg::EVT_ABS, 16'($urandom), $urandom);
      endcase
    end
  endfunction

  // Wait for every event to be taken and every point to be checked, then let
  // the block settle before touching the registers.
  task automatic wait_drained();
    while (pending_events.size() != 0 || ev_valid || expected_points.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register setting per random phase: fixed extremes first, then random.
  task automatic program_screen(input int unsigned phase);
    logic [31:0] w, h, rot, xm, ym;
    case (phase)
      0: begin
        w = 0;    h = 8191; rot = 0; xm = 0;     ym = 65535;   // size 0 and oversize
      end
      1: begin
        w = 4096; h = 4096; rot = 1; xm = 1;     ym = 1;       // largest screen, tiny span
      end
      2: begin
        w = 1;    h = 1;    rot = 1; xm = 65535; ym = 0;       // single-pixel screen
      end
      default: begin
        w   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
        h   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
        rot = $urandom_range(0, 1);
        xm  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4095);
        ym  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 4095);
        // junk above each register's width must be dropped
        w   = w   | ($urandom & 32'hffff_e000);
        h   = h   | ($urandom & 32'hffff_e000);
        rot = rot | ($urandom & 32'hffff_fffe);
        xm  = xm  | ($urandom & 32'hffff_0000);
        ym  = ym  | ($urandom & 32'hffff_0000);
      end
    endcase
    write_register(tmap_pkg::REG_LOGICAL_WIDTH,  w);
    write_register(tmap_pkg::REG_LOGICAL_HEIGHT, h);
    write_register(tmap_pkg::REG_ROTATE_MODE,    rot);
    write_register(tmap_pkg::REG_RAW_X_MAX,      xm);
    write_register(tmap_pkg::REG_RAW_Y_MAX,      ym);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed pass at reset settings (rotated, 1280x800, raw 1280x800)
    sender_idle_pct   = 21;
    receiver_idle_pct = 75;
    queue_event(tmap_pkg::EVT_SYN, 16'h0000, 32'h0);                  // point from reset state
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_X, 32'd640);
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_Y, 32'd400);
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_TRACK_ID, 32'd5);   // tracking id presses
    queue_event(tmap_pkg::EVT_SYN, 16'h0000, 32'h0);
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_X, 32'h7fff_ffff); // widest product
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_Y, 32'h8000_0000); // most negative
    queue_event(tmap_pkg::EVT_SYN, 16'hffff, 32'hffff_ffff);
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_TRACK_ID, tmap_pkg::TRACK_RELEASE); // release
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_X, 32'hffff_ffff); // -1 truncates to 0
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_POS_Y, 32'd800);    // flipped X lands on 0
    queue_event(tmap_pkg::EVT_SYN, 16'h0000, 32'h0);
    queue_event(tmap_pkg::EVT_KEY, tmap_pkg::CODE_TOUCH_BUTTON, 32'd1); // button seen, pressed
    queue_event(tmap_pkg::EVT_SYN, 16'h0000, 32'h0);
    queue_event(tmap_pkg::EVT_KEY, tmap_pkg::CODE_TOUCH_BUTTON, 32'd0);
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_TRACK_ID, 32'd7);   // no press once button seen
    queue_event(tmap_pkg::EVT_SYN, 16'h0000, 32'h0);
    queue_event(tmap_pkg::EVT_KEY, tmap_pkg::CODE_TOUCH_BUTTON, 32'h8000_0000); // nonzero presses
    queue_event(tmap_pkg::EVT_KEY, 16'h014b, 32'd0);                  // other key: ignored
    queue_event(tmap_pkg::EVT_ABS, 16'h0037, 32'd0);                  // other axis: ignored
    queue_event(16'h0002, tmap_pkg::CODE_POS_X, 32'd100);             // unknown type: ignored
    queue_event(16'hffff, 16'hffff, 32'h7fff_ffff);
    queue_event(tmap_pkg::EVT_SYN, 16'h0000, 32'h0);
    queue_event(tmap_pkg::EVT_ABS, tmap_pkg::CODE_TRACK_ID, 32'hffff_fffe); // -2 not a release
    queue_event(tmap_pkg::EVT_SYN, 16'h0000, 32'h0);
    wait_drained();

    // Random phases: sender-light/receiver-heavy idling, then the reverse, then none
    for (phase = 0; phase < NUM_CHUNKS; phase++) begin
      program_screen(phase);
      @(negedge clk_i);
      case (phase / 3)
        0: begin
          sender_idle_pct = 21; receiver_idle_pct = 75;
        end
        1: begin
          sender_idle_pct = 75; receiver_idle_pct = 21;
        end
        default: begin
          sender_idle_pct = 0;  receiver_idle_pct = 0;
        end
      endcase
      items_queued = 0;
      while (items_queued < CHUNK_ITEMS) begin
        queue_touch_frame();
      end
      // back up the output while the sender keeps offering events
      if (phase == 6) begin
        hold_requests++;
      end
      wait_drained();
    end

    $display("tb: %0d events accepted, %0d points checked", events_accepted, points_checked);
    $display("tb: %0d register settings incl. size/span extremes, one %0d-cycle output hold",
             settings_used, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tmap_pkg.sv
hw/rtl/touch_event_to_point_mapper.sv
tb/sv/tb.sv
